### sv/ttip_pkg.sv
// Shared types and constants for the text to integer parser.
package ttip_pkg;

  localparam int CHAR_W  = 8;
  localparam int BASE_W  = 6;
  localparam int MODE_W  = 2;
  localparam int DIGIT_W = 6;
  localparam int VALUE_W = 64;
  localparam int PROD_W  = VALUE_W + BASE_W + 1;

  localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
  localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;

  localparam logic [MODE_W-1:0] MODE_S32 = 2'd0;
  localparam logic [MODE_W-1:0] MODE_U32 = 2'd1;
  localparam logic [MODE_W-1:0] MODE_U64 = 2'd2;

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

  localparam logic [DIGIT_W-1:0] DIGIT_NONE = 6'h3F;

  localparam logic [VALUE_W-1:0] LIM_S32_POS = 64'h0000_0000_7FFF_FFFF;
  localparam logic [VALUE_W-1:0] LIM_S32_NEG = 64'h0000_0000_8000_0000;
  localparam logic [VALUE_W-1:0] LIM_U32     = 64'h0000_0000_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] LIM_U64     = 64'hFFFF_FFFF_FFFF_FFFF;

  // register indexes on the config port
  localparam logic REG_BASE = 1'b0;
  localparam logic REG_MODE = 1'b1;

  typedef struct packed {
    logic is_space;
    logic is_plus;
    logic minus_ok;
    logic is_digit;
    logic ovf;
  } ttip_status_t;

  typedef struct packed {
    logic take_digit;
    logic clear;
    logic capture;
    logic result_ok;
    logic negate;
  } ttip_cmd_t;

endpackage

### sv/ttip_dpath.sv
// Datapath: character classification, multiply-accumulate, range check, result register.
module ttip_dpath import ttip_pkg::*; (
  input  logic               clk,
  input  logic [CHAR_W-1:0]  char_code,
  input  logic [BASE_W-1:0]  number_base,
  input  logic [MODE_W-1:0]  parse_mode,
  input  ttip_cmd_t          cmd,
  output ttip_status_t       status,
  output logic [VALUE_W-1:0] parsed_value,
  output logic               parse_ok
);

  logic [VALUE_W-1:0] accumulator;
  logic [BASE_W-1:0]  eff_base;
  logic [DIGIT_W-1:0] digit_val;
  logic [VALUE_W-1:0] limit;
  logic [PROD_W-1:0]  sum;
  logic [VALUE_W-1:0] acc_final;

  always_comb begin
    if (number_base < BASE_MIN) begin
      eff_base = BASE_MIN;
    end else if (number_base > BASE_MAX) begin
      eff_base = BASE_MAX;
    end else begin
      eff_base = number_base;
    end
  end

  always_comb begin
    if (char_code >= 8'h30 && char_code <= 8'h39) begin
      digit_val = DIGIT_W'(char_code - 8'h30);
    end else if (char_code >= 8'h61 && char_code <= 8'h7A) begin
      digit_val = DIGIT_W'(char_code - 8'h61 + 8'd10);
    end else if (char_code >= 8'h41 && char_code <= 8'h5A) begin
      digit_val = DIGIT_W'(char_code - 8'h41 + 8'd10);
    end else begin
      digit_val = DIGIT_NONE;
    end
  end

  always_comb begin
    unique case (parse_mode)
      MODE_S32: limit = cmd.negate ? LIM_S32_NEG : LIM_S32_POS;
      MODE_U32: limit = LIM_U32;
      default:  limit = LIM_U64;
    endcase
  end

  // acc > (lim - dv) / b  is the same test as  acc * b + dv > lim
  assign sum = PROD_W'({{(PROD_W-VALUE_W){1'b0}}, accumulator} * {{(PROD_W-BASE_W){1'b0}}, eff_base})
             + {{(PROD_W-DIGIT_W){1'b0}}, digit_val};

  assign status.is_space = (char_code == CH_SPACE) || (char_code >= CH_TAB && char_code <= CH_CR);
  assign status.is_plus  = (char_code == CH_PLUS);
  assign status.minus_ok = (char_code == CH_MINUS) && (parse_mode == MODE_S32);
  assign status.is_digit = (digit_val < eff_base);
  assign status.ovf      = (sum > {{(PROD_W-VALUE_W){1'b0}}, limit});

  assign acc_final = cmd.take_digit ? sum[VALUE_W-1:0] : accumulator;

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      accumulator <= '0;
    end else if (cmd.take_digit) begin
      accumulator <= sum[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      parse_ok <= cmd.result_ok;
      if (!cmd.result_ok) begin
        parsed_value <= '0;
      end else if (cmd.negate) begin
        parsed_value <= '0 - acc_final;
      end else begin
        parsed_value <= acc_final;
      end
    end
  end

endmodule

### sv/ttip_ctrl.sv
// Controller: field phase, sign and failure tracking, stream handshake.
module ttip_ctrl import ttip_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic         has_char,
  input  logic         last_char,
  output logic         m_tvalid,
  input  logic         m_tready,
  input  ttip_status_t status,
  output ttip_cmd_t    cmd
);

  localparam logic [1:0] PH_LEAD   = 2'd0;
  localparam logic [1:0] PH_SIGNED = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_TRAIL  = 2'd3;

  logic [1:0] phase, phase_next;
  logic       negative, negative_next;
  logic       failed, failed_next;
  logic       fire, field_end, want_digit;

  assign s_tready  = !m_tvalid || m_tready;
  assign fire      = s_tvalid && s_tready;
  assign field_end = !has_char || last_char;

  always_comb begin
    phase_next    = phase;
    negative_next = negative;
    failed_next   = failed;
    want_digit    = 1'b0;
    if (has_char && !failed) begin
      unique case (phase)
        PH_LEAD: begin
          if (status.is_space) begin
            phase_next = PH_LEAD;
          end else if (status.is_plus) begin
            phase_next = PH_SIGNED;
          end else if (status.minus_ok) begin
            phase_next    = PH_SIGNED;
            negative_next = 1'b1;
          end else if (status.is_digit) begin
            want_digit = 1'b1;
          end else begin
            failed_next = 1'b1;
          end
        end
        PH_SIGNED: begin
          if (status.is_digit) begin
            want_digit = 1'b1;
          end else begin
            failed_next = 1'b1;
          end
        end
        PH_DIGITS: begin
          if (status.is_digit) begin
            want_digit = 1'b1;
          end else if (status.is_space) begin
            phase_next = PH_TRAIL;
          end else begin
            failed_next = 1'b1;
          end
        end
        PH_TRAIL: begin
          if (!status.is_space) begin
            failed_next = 1'b1;
          end
        end
        default: failed_next = 1'b1;
      endcase
    end
    // overflow fails the field and leaves the accumulator untouched
    if (want_digit) begin
      if (status.ovf) begin
        failed_next = 1'b1;
      end else begin
        phase_next = PH_DIGITS;
      end
    end
  end

  always_comb begin
    cmd.take_digit = fire && want_digit && !status.ovf;
    cmd.capture    = fire && field_end;
    // accumulator also cleared by reset
    cmd.clear      = rst || (fire && field_end);
    cmd.result_ok  = !failed_next && (phase_next == PH_DIGITS || phase_next == PH_TRAIL);
    cmd.negate     = negative;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_LEAD;
      negative <= 1'b0;
      failed   <= 1'b0;
    end else if (fire) begin
      if (field_end) begin
        phase    <= PH_LEAD;
        negative <= 1'b0;
        failed   <= 1'b0;
      end else begin
        phase    <= phase_next;
        negative <= negative_next;
        failed   <= failed_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire && field_end) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

### sv/text_to_integer_parser.sv
// The result is registered and appears in the cycle after the transaction that ends its field.
// Throughput: one character per cycle while the output is not stalled; the 64x6
// multiply-accumulate with its range compare is the combinational path that sets this.
// The output register frees in the same cycle it is taken, so no bubble between fields.
// Reset (synchronous): field state cleared, no result pending, base 10, signed 32-bit mode.
// A result is delivered when has_char is low or last_char is high.
module text_to_integer_parser import ttip_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tlast,   // last_char
  input  logic        s_tuser,   // has_char
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [63:0] parsed_value
  output logic        m_tuser,   // parse_ok
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [BASE_W-1:0] number_base;
  logic [MODE_W-1:0] parse_mode;
  ttip_status_t      status;
  ttip_cmd_t         cmd;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= BASE_RESET;
      parse_mode  <= MODE_S32;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_BASE: number_base <= pwdata[BASE_W-1:0];
        REG_MODE: parse_mode  <= pwdata[MODE_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BASE: prdata = {{(32-BASE_W){1'b0}}, number_base};
      REG_MODE: prdata = {{(32-MODE_W){1'b0}}, parse_mode};
      default:  prdata = '0;
    endcase
  end

  ttip_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .has_char  (s_tuser),
    .last_char (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .status    (status),
    .cmd       (cmd)
  );

  ttip_dpath u_dpath (
    .clk          (clk),
    .char_code    (s_tdata),
    .number_base  (number_base),
    .parse_mode   (parse_mode),
    .cmd          (cmd),
    .status       (status),
    .parsed_value (m_tdata),
    .parse_ok     (m_tuser)
  );

endmodule

### sv/ttip_checker.sv
// Port-level checks for the text to integer parser, bound to the top level.
module ttip_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // failed parse gives zero
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 64'd0)
    else $error("failed parse with nonzero value");

  // input side never stalls while the output register is empty
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result pending after reset");

endmodule

bind text_to_integer_parser ttip_checker u_ttip_checker (.*);
